@@ src/aqtc_pkg.sv @@
`timescale 1ns / 1ps

package aqtc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 21;
  localparam int TIME_BITS   = 32;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int ITER_BITS   = $clog2(SAMPLE_BITS + 1);
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_SAMPLE_INT  = 3'd1,
    REG_AVG_PERIOD  = 3'd2,
    REG_HIGH_STEP   = 3'd3,
    REG_LOW_STEP    = 3'd4,
    REG_FORCE_LEVEL = 3'd5,
    REG_HIGH_EXCESS = 3'd6,
    REG_LOW_EXCESS  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    Q_FRESH = 2'd0,
    Q_LOW   = 2'd1,
    Q_HIGH  = 2'd2,
    Q_FORCE = 2'd3
  } quality_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_PERIOD,
    S_DIV,
    S_CLASS,
    S_EMIT
  } seq_state_t;

endpackage

@@ src/aqtc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle. The quotient is known to fit
// SAMPLE_BITS since the sum never exceeds count times the largest sample.
module aqtc_div
  import aqtc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SUM_BITS-1:0]    dividend,
  input  logic [COUNT_BITS-1:0]  divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quotient
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [ITER_BITS-1:0]   cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0]    rem_r, rem_nxt;
  logic [SUM_BITS-1:0]    sh_r, sh_nxt;
  logic [COUNT_BITS-1:0]  divisor_r, divisor_nxt;
  logic [SAMPLE_BITS-1:0] q_r, q_nxt;
  logic                   ge;

  assign ge = (rem_r >= sh_r);

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    divisor_nxt = divisor_r;
    q_nxt       = q_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = ITER_BITS'(SAMPLE_BITS);
      rem_nxt     = dividend;
      sh_nxt      = SUM_BITS'(divisor) << (SAMPLE_BITS - 1);
      divisor_nxt = divisor;
      q_nxt       = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - sh_r;
      end
      q_nxt   = {q_r[SAMPLE_BITS-2:0], ge};
      sh_nxt  = sh_r >> 1;
      cnt_nxt = cnt_r - ITER_BITS'(1);
      if (cnt_r == ITER_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    divisor_r <= divisor_nxt;
    q_r       <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < SUM_BITS'(divisor_r)))
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider done while still busy");

endmodule

@@ src/air_quality_trend_classifier.sv @@
`timescale 1ns / 1ps

// Air quality trend classifier.
// Input beats (in_valid/in_ready) carry a millisecond time and a sensor
// reading; each one gives exactly one output beat (out_valid/out_ready)
// with taken, the held quality class and the held reference average.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register
// per cycle; the user must write it only while the block is idle, as the
// block itself does not enforce it.
// An input beat is worked through a small sequencer: capture, take test,
// period test, classify and emit. A beat that is not taken skips the period
// test and classification. When the average period has run out and samples
// were counted, the serial divider runs between the period test and
// classification; it makes the longest path through the sequencer.
// in_ready is high only in the idle state. A finished beat sits in the
// output register; the next input beat is accepted while it waits, but
// that item stops at emit until out_ready frees the register.
// After rst_n low all history, sum, count and average are zero, the
// quality is fresh and the registers hold their default values.
module air_quality_trend_classifier
  import aqtc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TIME_BITS-1:0]   in_time_ms,
  input  logic [SAMPLE_BITS-1:0] in_reading,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_taken,
  output logic [1:0]             out_quality,
  output logic [SAMPLE_BITS-1:0] out_average_level,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  // configuration
  logic        enable_r;
  logic [15:0] sample_int_r;
  logic [19:0] avg_period_r;
  logic [11:0] high_step_r, low_step_r, force_level_r, high_excess_r, low_excess_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b1;
      sample_int_r  <= 16'd1000;
      avg_period_r  <= 20'd10000;
      high_step_r   <= 12'd400;
      low_step_r    <= 12'd200;
      force_level_r <= 12'd700;
      high_excess_r <= 12'd150;
      low_excess_r  <= 12'd50;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      enable_r      <= cfg_wdata[0];
        REG_SAMPLE_INT:  sample_int_r  <= cfg_wdata[15:0];
        REG_AVG_PERIOD:  avg_period_r  <= cfg_wdata[19:0];
        REG_HIGH_STEP:   high_step_r   <= cfg_wdata[11:0];
        REG_LOW_STEP:    low_step_r    <= cfg_wdata[11:0];
        REG_FORCE_LEVEL: force_level_r <= cfg_wdata[11:0];
        REG_HIGH_EXCESS: high_excess_r <= cfg_wdata[11:0];
        REG_LOW_EXCESS:  low_excess_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  seq_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [SAMPLE_BITS-1:0] reading_r, reading_nxt;
  logic                   taken_r, taken_nxt;
  logic [TIME_BITS-1:0]   last_take_r, last_take_nxt;
  logic [TIME_BITS-1:0]   last_avg_r, last_avg_nxt;
  logic [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [1:0]             quality_r, quality_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_taken_r, out_taken_nxt;
  logic [1:0]             out_quality_r, out_quality_nxt;
  logic [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;

  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_q;

  logic [TIME_BITS-1:0]   elapsed;
  logic [TIME_BITS-1:0]   limit;
  logic                   elapsed_over;
  logic signed [SAMPLE_BITS:0] step, excess;
  logic                   step_high, step_low, excess_high, excess_low;
  logic                   cur_above_force, cur_below_force;
  quality_t               cls;

  aqtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // one shared wrap-safe elapsed-time subtract and compare
  always_comb begin
    if (state_r == S_PERIOD) begin
      elapsed = time_r - last_avg_r;
      limit   = TIME_BITS'(avg_period_r);
    end else begin
      elapsed = time_r - last_take_r;
      limit   = TIME_BITS'(sample_int_r);
    end
    elapsed_over = (elapsed > limit);
  end

  always_comb begin
    step            = $signed({1'b0, cur_r}) - $signed({1'b0, prev_r});
    excess          = $signed({1'b0, cur_r}) - $signed({1'b0, avg_r});
    step_high       = step > $signed({1'b0, high_step_r});
    step_low        = step > $signed({1'b0, low_step_r});
    excess_high     = excess > $signed({1'b0, high_excess_r});
    excess_low      = excess > $signed({1'b0, low_excess_r});
    cur_above_force = cur_r > force_level_r;
    cur_below_force = cur_r < force_level_r;
    if (step_high || cur_above_force) begin
      cls = Q_FORCE;
    end else if (excess_high) begin
      cls = Q_HIGH;
    end else if ((step_low && cur_below_force) || excess_low) begin
      cls = Q_LOW;
    end else begin
      cls = Q_FRESH;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    time_nxt        = time_r;
    reading_nxt     = reading_r;
    taken_nxt       = taken_r;
    last_take_nxt   = last_take_r;
    last_avg_nxt    = last_avg_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    avg_nxt         = avg_r;
    quality_nxt     = quality_r;
    out_valid_nxt   = out_valid_r;
    out_taken_nxt   = out_taken_r;
    out_quality_nxt = out_quality_r;
    out_avg_nxt     = out_avg_r;
    div_start       = 1'b0;
    in_ready        = 1'b0;

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          time_nxt    = in_time_ms;
          reading_nxt = in_reading;
          state_nxt   = S_TAKE;
        end
      end
      S_TAKE: begin
        if (enable_r && elapsed_over) begin
          taken_nxt     = 1'b1;
          prev_nxt      = cur_r;
          cur_nxt       = reading_r;
          last_take_nxt = time_r;
          if (count_r != '1) begin
            sum_nxt   = sum_r + SUM_BITS'(reading_r);
            count_nxt = count_r + COUNT_BITS'(1);
          end
          state_nxt = S_PERIOD;
        end else begin
          taken_nxt = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_PERIOD: begin
        if (elapsed_over) begin
          last_avg_nxt = time_r;
          sum_nxt      = '0;
          count_nxt    = '0;
          // divider latches sum and count at start
          if (count_r != '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_CLASS;
          end
        end else begin
          state_nxt = S_CLASS;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_nxt   = div_q;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        quality_nxt = cls;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_taken_nxt   = taken_r;
          out_quality_nxt = quality_r;
          out_avg_nxt     = avg_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_take_r <= '0;
      last_avg_r  <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      avg_r       <= '0;
      quality_r   <= Q_FRESH;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_take_r <= last_take_nxt;
      last_avg_r  <= last_avg_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      avg_r       <= avg_nxt;
      quality_r   <= quality_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r        <= time_nxt;
    reading_r     <= reading_nxt;
    taken_r       <= taken_nxt;
    out_taken_r   <= out_taken_nxt;
    out_quality_r <= out_quality_nxt;
    out_avg_r     <= out_avg_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_taken         = out_taken_r;
  assign out_quality       = out_quality_r;
  assign out_average_level = out_avg_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (count_r != '0))
    else $error("division started with zero count");

  a_div_to_class: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |=> (state_r == S_CLASS))
    else $error("sequencer missed divider result");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output beat loaded outside emit");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("sum held without count");

endmodule
